// ===== hdl/bloom_filter_fnv1a_core_defines.svh =====
// Assertion macros shared by the bloom filter RTL.
`ifndef BLOOM_FILTER_FNV1A_CORE_DEFINES_SVH
`define BLOOM_FILTER_FNV1A_CORE_DEFINES_SVH

// Implication or expression that must hold on every clock outside reset.
`define BFNV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition that must never be seen outside reset.
`define BFNV_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

// ===== hdl/bfnv_pkg.sv =====
// Shared constants and types for the bloom filter core.
package bfnv_pkg;

	parameter int HASH_W     = 64;
	parameter int BYTE_W     = 8;
	parameter int HC_W       = 5;
	parameter int BC_W       = 17;
	parameter int CFG_IDX_W  = 2;
	parameter int CFG_DATA_W = 17;

	// 64-bit FNV prime is 2^40 + 0x1b3
	parameter int FNV_SHIFT = 40;
	parameter int FNV_LO_W  = 9;
	parameter logic [FNV_LO_W-1:0] FNV_PRIME_LO = 9'h1b3;

	parameter logic [CFG_IDX_W-1:0] REG_HASH_COUNT = 2'd0;
	parameter logic [CFG_IDX_W-1:0] REG_BIT_COUNT  = 2'd1;

	parameter logic [HC_W-1:0] HASH_COUNT_RST = 5'd7;
	parameter logic [BC_W-1:0] BIT_COUNT_RST  = 17'd65536;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} bm_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mod_stat_t;

endpackage

// ===== hdl/bfnv_if.sv =====
// Channel interfaces: key byte input, result output, configuration write.
interface bfnv_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] key_byte;
	logic       has_byte;
	logic       last;

	modport source (output valid, mode, key_byte, has_byte, last, input ready);
	modport sink   (input valid, mode, key_byte, has_byte, last, output ready);
endinterface

interface bfnv_out_if;
	logic valid;
	logic ready;
	logic found;
	logic was_insert;

	modport source (output valid, found, was_insert, input ready);
	modport sink   (input valid, found, was_insert, output ready);
endinterface

interface bfnv_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [16:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/bfnv_fnv_step.sv =====
// Shared FNV-1a round: xor a byte into a hash, multiply by the 64-bit prime.
module bfnv_fnv_step (
	input  logic                           clk,
	input  logic                           en,
	input  logic [bfnv_pkg::HASH_W-1:0]    operand,
	input  logic [bfnv_pkg::BYTE_W-1:0]    key_byte,
	output logic [bfnv_pkg::HASH_W-1:0]    result
);
	import bfnv_pkg::*;

	localparam int HI_W = HASH_W - FNV_SHIFT;

	logic [HASH_W-1:0] x;
	logic [HASH_W-1:0] mul_s1;
	logic [HI_W-1:0]   hi_s1;

	assign x = operand ^ {{(HASH_W-BYTE_W){1'b0}}, key_byte};

	// low part of the prime in one narrow multiply, the 2^40 term by shift
	always_ff @(posedge clk) begin
		if (en) begin
			mul_s1 <= x * {{(HASH_W-FNV_LO_W){1'b0}}, FNV_PRIME_LO};
			hi_s1  <= x[HI_W-1:0];
		end
	end

	assign result = mul_s1 + {hi_s1, {FNV_SHIFT{1'b0}}};

endmodule

// ===== hdl/bfnv_mod_unit.sv =====
// Bit-serial restoring remainder: 64-bit hash modulo the filter size.
`include "bloom_filter_fnv1a_core_defines.svh"

module bfnv_mod_unit #(
	parameter  int MAX_BITS = 65536,
	localparam int BW = $clog2(MAX_BITS + 1),
	localparam int PW = $clog2(MAX_BITS)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [bfnv_pkg::HASH_W-1:0] dividend,
	input  logic [BW-1:0]               divisor,
	output logic [PW-1:0]               rem,
	output bfnv_pkg::mod_stat_t         stat
);
	import bfnv_pkg::*;

	localparam int CNT_W = $clog2(HASH_W);

	logic [HASH_W-1:0] div_q;
	logic [BW-1:0]     rem_q;
	logic [BW-1:0]     m_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [BW:0]       sh;
	logic [BW:0]       diff;
	logic              ge;

	assign sh   = {rem_q, div_q[HASH_W-1]};
	assign diff = sh - {1'b0, m_q};
	assign ge   = sh >= {1'b0, m_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(HASH_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one dividend bit per cycle, msb first
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= dividend;
			rem_q <= '0;
			m_q   <= divisor;
		end else if (busy_q) begin
			div_q <= div_q << 1;
			rem_q <= ge ? diff[BW-1:0] : sh[BW-1:0];
		end
	end

	assign rem       = rem_q[PW-1:0];
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	`BFNV_ASSERT(a_rem_below_m, done_q |-> (rem_q < m_q), "remainder not below divisor")

endmodule

// ===== hdl/bfnv_bit_mem.sv =====
// Filter bit store, one bit per entry, with a clearing pass after reset.
`include "bloom_filter_fnv1a_core_defines.svh"

module bfnv_bit_mem #(
	parameter  int MAX_BITS = 65536,
	localparam int PW = $clog2(MAX_BITS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bfnv_pkg::bm_cmd_t cmd,
	input  logic [PW-1:0]     addr,
	output logic              rdata,
	output logic              busy
);
	import bfnv_pkg::*;

	logic          mem [MAX_BITS];
	logic [PW-1:0] clr_addr_q;
	logic          clr_busy_q;
	logic          rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == PW'(MAX_BITS - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= 1'b0;
		end else if (cmd.wr_en) begin
			mem[addr] <= 1'b1;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;
	assign busy  = clr_busy_q;

	`BFNV_NEVER(a_no_access_clearing, clr_busy_q && (cmd.wr_en || cmd.rd_en),
		"bit store accessed during clearing pass")

endmodule

// ===== hdl/bloom_filter_fnv1a_core.sv =====
// Bloom filter core: byte-serial FNV-1a hashing, modulo reduction, bit store.
//
// req carries one key byte per beat (mode, key_byte, has_byte, last); rsp
// returns one beat (found, was_insert) per completed key; cfg writes
// hash_count (index 0) and bit_count (index 1) and is always ready.
// A beat with a byte runs all MAX_HASHES accumulators through one shared
// multiply stage, one hash at a time through the multiply and add states,
// so no new beat is taken until every accumulator has been updated.
// On a last beat each of the k hashes goes through the bit-serial remainder
// unit and one bit store access: a read and a check on a query, a write on
// an insert; a last beat with a byte hashes that byte first. rsp.valid rises
// once the result state loads the output register after the last hash.
// A beat with neither byte nor last is taken and has no effect.
// req.ready is low while a beat is in work.
// After reset the bit store is cleared one entry per cycle, all MAX_BITS entries
// (65536 by default), and req.ready stays low until that pass ends.
// Results sit in an output register: new beats are taken while a result
// waits, and a finished key holds in place until rsp takes the earlier one.
`include "bloom_filter_fnv1a_core_defines.svh"

module bloom_filter_fnv1a_core #(
	parameter int MAX_BITS   = 65536,
	parameter int MAX_HASHES = 16
) (
	input logic       clk,
	input logic       arst_n,
	bfnv_in_if.sink   req,
	bfnv_out_if.source rsp,
	bfnv_cfg_if.sink  cfg
);
	import bfnv_pkg::*;

	localparam int BW = $clog2(MAX_BITS + 1);
	localparam int PW = $clog2(MAX_BITS);
	localparam int HW = $clog2(MAX_HASHES + 1);
	localparam int IW = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HASH_MUL,
		ST_HASH_ADD,
		ST_RED_START,
		ST_RED_WAIT,
		ST_BIT_ACC,
		ST_BIT_CHK,
		ST_RESULT
	} state_t;

	state_t            state_q;
	logic [IW-1:0]     idx_q;
	logic              mode_q;
	logic [BYTE_W-1:0] byte_q;
	logic              has_byte_q;
	logic              last_q;
	logic              fresh_q;
	logic              kip_q;
	logic              all_set_q;
	logic              out_valid_q;
	logic              found_q;
	logic              was_insert_q;
	logic [HC_W-1:0]   hc_q;
	logic [BC_W-1:0]   bc_q;
	logic [HASH_W-1:0] acc_q [MAX_HASHES];

	logic [HW-1:0]     k_eff;
	logic [BW-1:0]     m_eff;
	logic [HASH_W-1:0] hash_src;
	logic [HASH_W-1:0] red_src;
	logic [HASH_W-1:0] fnv_result;
	logic [PW-1:0]     pos;
	mod_stat_t         mod_st;
	bm_cmd_t           bm_cmd;
	logic              bm_rdata;
	logic              mem_busy;
	logic              in_acc;
	logic              last_hash;

	assign k_eff = (hc_q == '0) ? HW'(1) :
		(32'(hc_q) > 32'(MAX_HASHES)) ? HW'(MAX_HASHES) : HW'(hc_q);
	assign m_eff = (bc_q == '0) ? BW'(1) :
		(32'(bc_q) > 32'(MAX_BITS)) ? BW'(MAX_BITS) : BW'(bc_q);

	// a fresh key reads seeds until its first byte has been absorbed
	assign hash_src = fresh_q ? HASH_W'(idx_q) : acc_q[idx_q];
	assign red_src  = (fresh_q && !has_byte_q) ? HASH_W'(idx_q) : acc_q[idx_q];

	assign last_hash = (HW'(idx_q) + HW'(1)) == k_eff;

	assign req.ready = (state_q == ST_IDLE) && !mem_busy;
	assign in_acc    = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	assign rsp.valid      = out_valid_q;
	assign rsp.found      = found_q;
	assign rsp.was_insert = was_insert_q;

	assign bm_cmd.rd_en = (state_q == ST_BIT_ACC) && !mode_q;
	assign bm_cmd.wr_en = (state_q == ST_BIT_ACC) && mode_q;

	bfnv_fnv_step u_fnv (
		.clk      (clk),
		.en       (state_q == ST_HASH_MUL),
		.operand  (hash_src),
		.key_byte (byte_q),
		.result   (fnv_result)
	);

	bfnv_mod_unit #(.MAX_BITS(MAX_BITS)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_RED_START),
		.dividend (red_src),
		.divisor  (m_eff),
		.rem      (pos),
		.stat     (mod_st)
	);

	bfnv_bit_mem #(.MAX_BITS(MAX_BITS)) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (bm_cmd),
		.addr   (pos),
		.rdata  (bm_rdata),
		.busy   (mem_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hc_q <= HASH_COUNT_RST;
			bc_q <= BIT_COUNT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_HASH_COUNT: hc_q <= cfg.data[HC_W-1:0];
				REG_BIT_COUNT:  bc_q <= cfg.data[BC_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_HASH_ADD) begin
			acc_q[idx_q] <= fnv_result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			mode_q       <= 1'b0;
			byte_q       <= '0;
			has_byte_q   <= 1'b0;
			last_q       <= 1'b0;
			fresh_q      <= 1'b0;
			kip_q        <= 1'b0;
			all_set_q    <= 1'b1;
			out_valid_q  <= 1'b0;
			found_q      <= 1'b0;
			was_insert_q <= 1'b0;
		end else begin
			// in the result state a taken beat is replaced by the new one
			if (rsp.valid && rsp.ready && (state_q != ST_RESULT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (req.has_byte || req.last)) begin
						mode_q     <= req.mode;
						byte_q     <= req.key_byte;
						has_byte_q <= req.has_byte;
						last_q     <= req.last;
						fresh_q    <= !kip_q;
						idx_q      <= '0;
						all_set_q  <= 1'b1;
						state_q    <= req.has_byte ? ST_HASH_MUL : ST_RED_START;
					end
				end
				ST_HASH_MUL: begin
					state_q <= ST_HASH_ADD;
				end
				ST_HASH_ADD: begin
					if (idx_q == IW'(MAX_HASHES - 1)) begin
						idx_q <= '0;
						if (last_q) begin
							state_q <= ST_RED_START;
						end else begin
							kip_q   <= 1'b1;
							state_q <= ST_IDLE;
						end
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_HASH_MUL;
					end
				end
				ST_RED_START: begin
					state_q <= ST_RED_WAIT;
				end
				ST_RED_WAIT: begin
					if (mod_st.done) begin
						state_q <= ST_BIT_ACC;
					end
				end
				ST_BIT_ACC: begin
					if (!mode_q) begin
						state_q <= ST_BIT_CHK;
					end else if (last_hash) begin
						state_q <= ST_RESULT;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_RED_START;
					end
				end
				ST_BIT_CHK: begin
					all_set_q <= all_set_q && bm_rdata;
					if (last_hash) begin
						state_q <= ST_RESULT;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_RED_START;
					end
				end
				ST_RESULT: begin
					// hold until the output register is free
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						found_q      <= !mode_q && all_set_q;
						was_insert_q <= mode_q;
						kip_q        <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`BFNV_ASSERT(a_out_from_result, $rose(out_valid_q) |-> $past(state_q == ST_RESULT),
		"result beat raised outside result state")
	`BFNV_ASSERT(a_check_only_query, (state_q == ST_BIT_CHK) |-> !mode_q,
		"bit check entered on an insert")
	`BFNV_NEVER(a_mod_idle, (state_q == ST_IDLE) && mod_st.busy,
		"remainder unit busy while idle")

endmodule
